FILE: design/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, constants and the hex segment encoder for the seven-segment
// scan shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

  localparam int unsigned DIGITS      = 6;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned SHIFT_BITS  = 16;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned DIV_W       = 8;
  localparam int unsigned DWELL_W     = 16;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic [DIV_W-1:0]   TICK_DIVIDE_RST = 8'd14;
  localparam logic [DWELL_W-1:0] DWELL_TICKS_RST = 16'd450;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

  typedef enum logic [1:0] {
    KIND_SCAN  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic {
    REG_TICK_DIVIDE = 1'b0,
    REG_DWELL_TICKS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             data;
    logic             pulse;
    logic             done;
    logic [POS_W-1:0] position;
  } scan_res_t;

  function automatic logic [7:0] seg_encode(input logic [DIGIT_W-1:0] value);
    logic [7:0] seg;
    case (value)
      4'h0:    seg = 8'h3f;
      4'h1:    seg = 8'h06;
      4'h2:    seg = 8'h5b;
      4'h3:    seg = 8'h4f;
      4'h4:    seg = 8'h66;
      4'h5:    seg = 8'h6d;
      4'h6:    seg = 8'h7d;
      4'h7:    seg = 8'h07;
      4'h8:    seg = 8'h7f;
      4'h9:    seg = 8'h6f;
      4'ha:    seg = 8'h77;
      4'hb:    seg = 8'h7c;
      4'hc:    seg = 8'h39;
      4'hd:    seg = 8'h5e;
      4'he:    seg = 8'h79;
      4'hf:    seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

FILE: design/sss_scan.sv
// ----------------------------------------------------------------------------
// sss_scan
// Scan sequencer: position, bit and dwell counters, and the serial bit of the
// select byte and segment byte for the current position.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_scan import sss_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [DIGIT_W-1:0] digit_i,
  input  wire logic [DWELL_W-1:0] dwell_ticks_i,
  output logic      [POS_W-1:0]   pos_o,
  output scan_res_t               res_o
);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [DWELL_W-1:0] dwell_q, dwell_d, dwell_dec;
  logic [SHIFT_BITS-1:0] word;
  logic [7:0]         sel_byte;
  logic [POS_W-1:0]   pos_next;
  logic               shifting;

  assign sel_byte  = ~(8'd1 << pos_q);
  assign word      = {sel_byte, seg_encode(digit_i)};
  assign shifting  = (bit_q < BIT_W'(SHIFT_BITS));
  assign pos_next  = (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
  assign dwell_dec = dwell_q - DWELL_W'(dwell_q != '0);

  always_comb begin
    pos_d   = pos_q;
    bit_d   = bit_q;
    dwell_d = dwell_q;
    res_o.data  = 1'b0;
    res_o.pulse = 1'b0;
    res_o.done  = 1'b0;
    if (step_i) begin
      if (shifting) begin
        res_o.data  = word[4'(SHIFT_BITS - 1) - bit_q[3:0]];
        res_o.pulse = 1'b1;
        bit_d       = bit_q + BIT_W'(1);
        if (bit_q == BIT_W'(SHIFT_BITS - 1)) begin
          res_o.done = 1'b1;
          dwell_d    = dwell_ticks_i;
          if (dwell_ticks_i == '0) begin
            pos_d = pos_next;
            bit_d = '0;
          end
        end
      end else begin
        dwell_d = dwell_dec;
        if (dwell_dec == '0) begin
          pos_d = pos_next;
          bit_d = '0;
        end
      end
    end
    res_o.position = pos_d;
  end

  assign pos_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bit_q   <= '0;
      dwell_q <= '0;
    end else begin
      pos_q   <= pos_d;
      bit_q   <= bit_d;
      dwell_q <= dwell_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/seven_segment_scan_shifter_top.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_shifter_top
// Six-digit multiplexed hex display driver feeding an external serial-in
// shift register, with a digit store and a tick divider on digit zero.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i/in_ready_o) carries one command per transfer:
//   scan tick, count tick or digit write. each accepted command yields
//   exactly one result transfer on the output channel (out_valid_o/
//   out_ready_i) with the shift line level, strobe, scan position, frame
//   done flag and digit zero.
//   the result sits in an output register the cycle after the command is
//   taken. throughput is one command per cycle while the receiver drains
//   results; the state update is a single pass of short logic per command.
//   in_ready_o is high while the output register is empty or being drained,
//   so a stalled receiver holds the result and stops intake after one item.
//   reset clears the digit store, divider, scan counters and the output
//   valid; tick_divide returns to 14 and dwell_ticks to 450.
//   registers sit on the apb port at 0x0 (tick_divide) and 0x4 (dwell_ticks).
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_shifter_top import sss_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic      [APB_DW-1:0]  prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [POS_W-1:0]   digit_sel_i,
  input  wire logic [DIGIT_W-1:0] digit_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    serial_data_o,
  output logic                    shift_pulse_o,
  output logic      [POS_W-1:0]   scan_position_o,
  output logic                    frame_done_o,
  output logic      [DIGIT_W-1:0] counting_digit_o
);

  logic [DIV_W-1:0]   tick_divide_q;
  logic [DWELL_W-1:0] dwell_ticks_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  logic [DIGIT_W-1:0] store_q [DIGITS];
  logic [DIGIT_W-1:0] store_d [DIGITS];
  logic [DIV_W-1:0]   div_q, div_d;
  logic [DIV_W:0]     div_inc;

  logic               accept;
  kind_e              kind;
  logic [POS_W-1:0]   scan_pos;
  scan_res_t          scan_res;
  logic [DIGIT_W-1:0] shown_digit;

  logic               out_valid_q;
  scan_res_t          res_q;
  logic [DIGIT_W-1:0] digit0_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_TICK_DIVIDE: prdata = APB_DW'(tick_divide_q);
      REG_DWELL_TICKS: prdata = APB_DW'(dwell_ticks_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_divide_q <= TICK_DIVIDE_RST;
      dwell_ticks_q <= DWELL_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TICK_DIVIDE: tick_divide_q <= pwdata[DIV_W-1:0];
        REG_DWELL_TICKS: dwell_ticks_q <= pwdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // command handling
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign kind       = kind_e'(kind_i);

  assign shown_digit = store_q[LAST_POS - scan_pos];

  sss_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept && (kind == KIND_SCAN)),
    .digit_i       (shown_digit),
    .dwell_ticks_i (dwell_ticks_q),
    .pos_o         (scan_pos),
    .res_o         (scan_res)
  );

  assign div_inc = {1'b0, div_q} + (DIV_W+1)'(1);

  always_comb begin
    store_d = store_q;
    div_d   = div_q;
    if (accept) begin
      case (kind)
        KIND_COUNT: begin
          if (div_inc >= {1'b0, tick_divide_q}) begin
            div_d      = '0;
            store_d[0] = store_q[0] + DIGIT_W'(1);
          end else begin
            div_d = div_inc[DIV_W-1:0];
          end
        end
        KIND_WRITE: begin
          if (digit_sel_i <= LAST_POS) begin
            store_d[digit_sel_i] = digit_value_i;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '{default: '0};
      div_q   <= '0;
    end else begin
      store_q <= store_d;
      div_q   <= div_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q    <= scan_res;
      digit0_q <= store_d[0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign serial_data_o    = res_q.data;
  assign shift_pulse_o    = res_q.pulse;
  assign frame_done_o     = res_q.done;
  assign scan_position_o  = res_q.position;
  assign counting_digit_o = digit0_q;

`ifndef SYNTH
  a_done_is_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> shift_pulse_o)
    else $error("frame done without a shift strobe");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scan_position_o <= LAST_POS)
    else $error("scan position out of range");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted command produced no result");

  a_count_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind == KIND_SCAN |=> $stable(div_q))
    else $error("divider moved on a scan tick");
`endif

endmodule

`default_nettype wire

FILE: bench/scan_check_pkg.sv
// ----------------------------------------------------------------------------
// scan_check_pkg
// Scoreboard for the seven-segment scan shifter. It tracks the digit store,
// tick divider and scan counters, works out the step each command causes
// and checks the result transfers against those steps in order.
// ----------------------------------------------------------------------------
package scan_check_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  typedef struct packed {
    logic               serial;
    logic               strobe;
    logic [POS_W-1:0]   position;
    logic               frame_end;
    logic [DIGIT_W-1:0] digit0;
  } scan_step_t;

  localparam logic [7:0] HEX_SEGMENTS [16] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
  };

  class scan_scoreboard;

    logic [DIGIT_W-1:0] digits [DIGITS];
    logic [DIV_W-1:0]   div_count;
    logic [POS_W-1:0]   pos;
    logic [BIT_W-1:0]   bit_idx;
    logic [DWELL_W-1:0] dwell_left;
    logic [DIV_W-1:0]   divide_cfg;
    logic [DWELL_W-1:0] dwell_cfg;
    scan_step_t         step_q [$];
    int unsigned        mismatches;

    function new();
      foreach (digits[i]) digits[i] = '0;
      div_count  = '0;
      pos        = '0;
      bit_idx    = '0;
      dwell_left = '0;
      divide_cfg = TICK_DIVIDE_RST;
      dwell_cfg  = DWELL_TICKS_RST;
      mismatches = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_TICK_DIVIDE: divide_cfg = value[DIV_W-1:0];
        REG_DWELL_TICKS: dwell_cfg = value[DWELL_W-1:0];
        default: ;
      endcase
    endfunction

    function void move_on();
      if (pos == LAST_POS) pos = '0;
      else pos++;
      bit_idx = '0;
    endfunction

    function void note_command(kind_e kind, logic [POS_W-1:0] sel,
                               logic [DIGIT_W-1:0] val);
      scan_step_t  s;
      logic [15:0] word;
      logic [8:0]  next_count;
      s = '0;
      case (kind)
        KIND_SCAN: begin
          if (bit_idx < SHIFT_BITS) begin
            word = {~(8'd1 << pos), HEX_SEGMENTS[digits[DIGITS - 1 - pos]]};
            s.serial    = word[15 - bit_idx];
            s.strobe    = 1'b1;
            s.frame_end = (bit_idx == SHIFT_BITS - 1);
            bit_idx++;
            if (bit_idx == SHIFT_BITS) begin
              dwell_left = dwell_cfg;
              if (dwell_left == 0) move_on();
            end
          end else begin
            if (dwell_left > 0) dwell_left--;
            if (dwell_left == 0) move_on();
          end
        end
        KIND_COUNT: begin
          next_count = {1'b0, div_count} + 9'd1;
          if (next_count >= {1'b0, divide_cfg}) begin
            div_count = '0;
            digits[0]++;
          end else begin
            div_count = next_count[DIV_W-1:0];
          end
        end
        KIND_WRITE: begin
          if (sel < DIGITS) digits[sel] = val;
        end
        default: ;
      endcase
      s.position = pos;
      s.digit0   = digits[0];
      step_q.push_back(s);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        mismatches++;
        $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_step(scan_step_t got);
      scan_step_t exp_s;
      if (step_q.size() == 0) begin
        mismatches++;
        $display("%0t result transfer with nothing expected: %0h", $time, got);
        return;
      end
      exp_s = step_q.pop_front();
      compare_field("serial_data", exp_s.serial, got.serial);
      compare_field("shift_pulse", exp_s.strobe, got.strobe);
      compare_field("scan_position", exp_s.position, got.position);
      compare_field("frame_done", exp_s.frame_end, got.frame_end);
      compare_field("counting_digit", exp_s.digit0, got.digit0);
    endfunction

    function int unsigned pending();
      return step_q.size();
    endfunction

  endclass

endpackage

FILE: bench/seven_segment_scan_shifter_top_tb.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_shifter_top_tb
// Drives scan ticks, count ticks and digit writes into the scan shifter with
// random idle bursts on both channels, rewrites the divide and dwell
// registers between phases, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module seven_segment_scan_shifter_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;
  import scan_check_pkg::*;

  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_CMDS = 195;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         cmd_kind;
  logic [POS_W-1:0]   cmd_sel;
  logic [DIGIT_W-1:0] cmd_value;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               serial_data;
  logic               shift_pulse;
  logic [POS_W-1:0]   scan_position;
  logic               frame_done;
  logic [DIGIT_W-1:0] counting_digit;

  bit in_idle_en  = 1'b0;
  bit out_idle_en = 1'b0;

  int unsigned divide_plan [PHASES] = '{0, 255, 10, 1, 0, 0, 0, 14};
  int unsigned dwell_plan  [PHASES] = '{0, 65535, 3, 1, 0, 0, 0, 2};

  scan_scoreboard sb;

  seven_segment_scan_shifter_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (cmd_kind),
    .digit_sel_i     (cmd_sel),
    .digit_value_i   (cmd_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .serial_data_o   (serial_data),
    .shift_pulse_o   (shift_pulse),
    .scan_position_o (scan_position),
    .frame_done_o    (frame_done),
    .counting_digit_o(counting_digit)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        sb.check_step('{serial_data, shift_pulse, scan_position, frame_done,
                        counting_digit});
      end
      if (in_valid && in_ready) begin
        sb.note_command(kind_e'(cmd_kind), cmd_sel, cmd_value);
      end
    end
  end

  // receiver stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (out_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_cmd(input kind_e kind, input logic [POS_W-1:0] sel,
                          input logic [DIGIT_W-1:0] val);
    @(negedge clk_i);
    if (in_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd_kind  <= kind;
    cmd_sel   <= sel;
    cmd_value <= val;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_random_cmd();
    int unsigned pick;
    kind_e       kind;
    pick = $urandom_range(0, 99);
    if (pick < 65) kind = KIND_SCAN;
    else if (pick < 80) kind = KIND_COUNT;
    else if (pick < 95) kind = KIND_WRITE;
    else kind = KIND_NONE;
    send_cmd(kind, POS_W'($urandom_range(0, 7)), DIGIT_W'($urandom_range(0, 15)));
  endtask

  // stop sending and let every outstanding step come back
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    cmd_kind  = KIND_SCAN;
    cmd_sel   = '0;
    cmd_value = '0;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // out-of-range selects, unused kind, one full frame and two dwell ticks
    send_cmd(KIND_WRITE, 3'd0, 4'hf);
    send_cmd(KIND_WRITE, 3'd5, 4'h8);
    send_cmd(KIND_WRITE, 3'd6, 4'ha);
    send_cmd(KIND_WRITE, 3'd7, 4'h5);
    send_cmd(KIND_NONE, 3'd7, 4'hf);
    send_cmd(KIND_COUNT, 3'd0, 4'h0);
    repeat (SHIFT_BITS) send_cmd(KIND_SCAN, 3'd0, 4'h0);
    send_cmd(KIND_SCAN, 3'd7, 4'hf);
    send_cmd(KIND_SCAN, 3'd0, 4'h0);
    send_cmd(KIND_WRITE, 3'd4, 4'h0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p >= 4 && p < PHASES - 1) begin
        divide_plan[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(2, 40);
        dwell_plan[p]  = $urandom_range(0, 8);
      end
      reg_write(REG_TICK_DIVIDE, divide_plan[p]);
      reg_write(REG_DWELL_TICKS, dwell_plan[p]);
      for (int n = 0; n < PHASE_CMDS; n++) begin
        if (n % 48 == 0) begin
          in_idle_en  = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
          out_idle_en = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        send_random_cmd();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sss_pkg.sv
design/sss_scan.sv
design/seven_segment_scan_shifter_top.sv
bench/scan_check_pkg.sv
bench/seven_segment_scan_shifter_top_tb.sv
